// File: rtl/core/prcd_pkg.sv
// ----------------------------------------------------------------------------
// prcd_pkg
// Shared constants and types for the palette run-length chunk decoder.
// ----------------------------------------------------------------------------
package prcd_pkg;

    localparam int ADDR_BITS  = 16;
    localparam int OFF_W      = 6;
    localparam int CB_W       = ADDR_BITS - OFF_W;
    localparam int CNT_W      = OFF_W + 1;
    localparam int SEG_W      = 10;
    localparam int OUT_ADDR_W = 16;
    localparam int RGB_W      = 24;
    localparam int COL_W      = 3;
    localparam int PAL_DEPTH  = 1 << COL_W;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    localparam logic [SEG_W-1:0] SEG_RESET    = SEG_W'(56);
    localparam logic [CNT_W-1:0] CHUNK_SIZE   = CNT_W'(64);
    localparam logic [OFF_W-1:0] LAST_OFF     = '1;
    localparam logic [RGB_W-1:0] PAL_DEFAULT  = 24'hFFFFFF;

    localparam logic [1:0] PH_COUNT = 2'd0;
    localparam logic [1:0] PH_BLUE  = 2'd1;
    localparam logic [1:0] PH_GREEN = 2'd2;
    localparam logic [1:0] PH_RED   = 2'd3;

    typedef struct packed {
        logic [CB_W-1:0]  chunk;
        logic [OFF_W-1:0] tail_off;
        logic [CNT_W-1:0] tail_cnt;
        logic [OFF_W-1:0] head_off;
        logic [CNT_W-1:0] head_cnt;
        logic [RGB_W-1:0] rgb;
        logic             opaque;
        logic             ovr;
    } t_cmd;

endpackage

// File: rtl/core/palette_rle_chunk_decoder.sv
// ----------------------------------------------------------------------------
// palette_rle_chunk_decoder
// Palette run-length sprite decoder: stream bytes in, pixel writes out.
//
//   channel | handshake                     | payload
//   --------+-------------------------------+-----------------------------------
//   in      | i_in_valid  / o_in_ready      | i_kind, i_data_byte
//   out     | o_out_valid / i_out_ready     | o_pixel_addr, o_red/green/blue,
//           |                               | o_opaque, o_last, o_overrun
//   cfg     | i_cfg_valid / o_cfg_ready     | i_segment_chunks
//
// Front takes one byte per cycle while the 4-entry command queue has room.
// Back emits one pixel per cycle unless stalled; a byte with a run of N pixels
// gives N writes, header and empty-run bytes none. Output register decouples
// stalls. Synchronous reset clears control; no clearing pass is needed.
// ----------------------------------------------------------------------------
module palette_rle_chunk_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_kind,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [prcd_pkg::SEG_W-1:0]       i_segment_chunks,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [prcd_pkg::OUT_ADDR_W-1:0]  o_pixel_addr,
    output logic [7:0]                       o_red,
    output logic [7:0]                       o_green,
    output logic [7:0]                       o_blue,
    output logic                             o_opaque,
    output logic                             o_last,
    output logic                             o_overrun
);
    import prcd_pkg::*;

    t_cmd push_cmd, pop_cmd;
    logic push, full, cmd_valid, pop;

    prcd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_data_byte      (i_data_byte),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_segment_chunks (i_segment_chunks),
        .o_push           (push),
        .o_cmd            (push_cmd),
        .i_full           (full)
    );

    prcd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .o_valid (cmd_valid),
        .i_pop   (pop),
        .o_cmd   (pop_cmd)
    );

    prcd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .o_pop        (pop),
        .i_cmd        (pop_cmd),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_addr (o_pixel_addr),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_opaque     (o_opaque),
        .o_last       (o_last),
        .o_overrun    (o_overrun)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("command pushed into full queue");

    a_transparent_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_opaque) |-> (o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0))
        else $error("transparent pixel with nonzero color");

    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> cmd_valid)
        else $error("pop from empty queue");

    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

// File: rtl/core/prcd_front.sv
// ----------------------------------------------------------------------------
// prcd_front
// Accepts stream bytes, tracks header, palette and chunk state, and issues
// one run command per pixel-producing byte.
// ----------------------------------------------------------------------------
module prcd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_kind,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [prcd_pkg::SEG_W-1:0]   i_segment_chunks,
    output logic                         o_push,
    output prcd_pkg::t_cmd               o_cmd,
    input  logic                         i_full
);
    import prcd_pkg::*;

    logic [SEG_W-1:0] r_seg_chunks;
    logic [RGB_W-1:0] r_pal [PAL_DEPTH];
    logic [RGB_W-1:0] n_pal [PAL_DEPTH];
    logic [1:0]       r_phase, n_phase;
    logic [7:0]       r_colours, n_colours;
    logic [7:0]       r_widx, n_widx;
    logic             r_tail_pend, n_tail_pend;
    logic [3:0]       r_pend_head, n_pend_head;
    logic [COL_W-1:0] r_colour, n_colour;
    logic [CB_W-1:0]  r_chunk, n_chunk;
    logic [OFF_W-1:0] r_hoff, n_hoff;
    logic [OFF_W-1:0] r_toff, n_toff;
    logic [CNT_W-1:0] r_space, n_space;
    logic [SEG_W-1:0] r_seg_left, n_seg_left;

    logic accept;

    assign o_in_ready  = !i_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        logic [5:0]       v_head_raw;
        logic [5:0]       v_tail_raw;
        logic [CNT_W-1:0] v_tail;
        logic [CNT_W-1:0] v_head;
        logic [CNT_W-1:0] v_space2;
        logic [COL_W-1:0] v_col;
        logic             v_run;
        logic             v_ovr;
        logic             v_ok;

        n_pal       = r_pal;
        n_phase     = r_phase;
        n_colours   = r_colours;
        n_widx      = r_widx;
        n_tail_pend = r_tail_pend;
        n_pend_head = r_pend_head;
        n_colour    = r_colour;
        n_chunk     = r_chunk;
        n_hoff      = r_hoff;
        n_toff      = r_toff;
        n_space     = r_space;
        n_seg_left  = r_seg_left;
        o_push      = 1'b0;
        o_cmd       = '0;
        v_head_raw  = '0;
        v_tail_raw  = '0;
        v_tail      = '0;
        v_head      = '0;
        v_space2    = '0;
        v_col       = r_colour;
        v_run       = 1'b0;
        v_ovr       = 1'b0;
        v_ok        = (r_widx >= 8'd1) && (r_widx < 8'(PAL_DEPTH));

        if (accept) begin
            if (i_kind) begin
                for (int k = 0; k < PAL_DEPTH; k++) begin
                    n_pal[k] = (k == 0) ? '0 : PAL_DEFAULT;
                end
                n_phase     = PH_COUNT;
                n_colours   = 8'hFF;
                n_widx      = 8'd1;
                n_tail_pend = 1'b0;
                n_pend_head = '0;
                n_colour    = COL_W'(1);
                n_chunk     = '0;
                n_hoff      = '0;
                n_toff      = LAST_OFF;
                n_space     = CHUNK_SIZE;
                n_seg_left  = r_seg_chunks;
            end else begin
                if (r_space == '0) begin
                    n_chunk    = r_chunk + CB_W'(1);
                    n_hoff     = '0;
                    n_toff     = LAST_OFF;
                    n_space    = CHUNK_SIZE;
                    n_seg_left = r_seg_left - SEG_W'(1);
                    if (n_seg_left == '0) begin
                        n_seg_left = r_seg_chunks;
                        n_phase    = PH_COUNT;
                        n_colours  = 8'hFF;
                        n_widx     = 8'd1;
                    end
                end
                v_ok = (n_widx >= 8'd1) && (n_widx < 8'(PAL_DEPTH));

                if (n_colours != 8'd0) begin
                    case (n_phase)
                        PH_COUNT: begin
                            n_colours = i_data_byte;
                            n_phase   = PH_BLUE;
                        end
                        PH_BLUE: begin
                            if (v_ok) n_pal[n_widx[COL_W-1:0]][7:0] = i_data_byte;
                            n_phase = PH_GREEN;
                        end
                        PH_GREEN: begin
                            if (v_ok) n_pal[n_widx[COL_W-1:0]][15:8] = i_data_byte;
                            n_phase = PH_RED;
                        end
                        default: begin
                            if (v_ok) n_pal[n_widx[COL_W-1:0]][23:16] = i_data_byte;
                            n_phase   = PH_BLUE;
                            n_widx    = n_widx + 8'd1;
                            n_colours = n_colours - 8'd1;
                        end
                    endcase
                end else begin
                    if (r_tail_pend) begin
                        v_head_raw  = {r_pend_head, i_data_byte[7:6]};
                        v_tail_raw  = i_data_byte[5:0];
                        n_tail_pend = 1'b0;
                        v_run       = 1'b1;
                    end else begin
                        v_col      = i_data_byte[7:5];
                        n_colour   = v_col;
                        v_head_raw = {2'b00, i_data_byte[3:0]};
                        if (i_data_byte[4]) begin
                            n_pend_head = i_data_byte[3:0];
                            n_tail_pend = 1'b1;
                        end else begin
                            v_run = 1'b1;
                        end
                    end

                    if (v_run) begin
                        v_tail = {1'b0, v_tail_raw};
                        if (v_tail > n_space) begin
                            v_tail = n_space;
                            v_ovr  = 1'b1;
                        end
                        v_space2 = n_space - v_tail;
                        v_head   = {1'b0, v_head_raw};
                        if (v_head > v_space2) begin
                            v_head = v_space2;
                            v_ovr  = 1'b1;
                        end
                        o_cmd.chunk    = n_chunk;
                        o_cmd.tail_off = n_toff;
                        o_cmd.tail_cnt = v_tail;
                        o_cmd.head_off = n_hoff;
                        o_cmd.head_cnt = v_head;
                        o_cmd.rgb      = r_pal[v_col];
                        o_cmd.opaque   = (v_col != '0);
                        o_cmd.ovr      = v_ovr;
                        o_push         = (v_tail != '0) || (v_head != '0);
                        n_toff         = n_toff - v_tail[OFF_W-1:0];
                        n_hoff         = n_hoff + v_head[OFF_W-1:0];
                        n_space        = v_space2 - v_head;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_chunks <= SEG_RESET;
            for (int k = 0; k < PAL_DEPTH; k++) begin
                r_pal[k] <= (k == 0) ? '0 : PAL_DEFAULT;
            end
            r_phase     <= PH_COUNT;
            r_colours   <= 8'hFF;
            r_widx      <= 8'd1;
            r_tail_pend <= 1'b0;
            r_pend_head <= '0;
            r_colour    <= COL_W'(1);
            r_chunk     <= '0;
            r_hoff      <= '0;
            r_toff      <= LAST_OFF;
            r_space     <= CHUNK_SIZE;
            r_seg_left  <= SEG_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_seg_chunks <= i_segment_chunks;
            end
            r_pal       <= n_pal;
            r_phase     <= n_phase;
            r_colours   <= n_colours;
            r_widx      <= n_widx;
            r_tail_pend <= n_tail_pend;
            r_pend_head <= n_pend_head;
            r_colour    <= n_colour;
            r_chunk     <= n_chunk;
            r_hoff      <= n_hoff;
            r_toff      <= n_toff;
            r_space     <= n_space;
            r_seg_left  <= n_seg_left;
        end
    end

endmodule

// File: rtl/core/prcd_fifo.sv
// ----------------------------------------------------------------------------
// prcd_fifo
// Short register queue of run commands between front and back.
// ----------------------------------------------------------------------------
module prcd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  prcd_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output prcd_pkg::t_cmd o_cmd
);
    import prcd_pkg::*;

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr, r_rptr;
    logic [FIFO_CW-1:0] r_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + FIFO_AW'(1);
            if (do_pop)  r_rptr <= r_rptr + FIFO_AW'(1);
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + FIFO_CW'(1);
                2'b01:   r_count <= r_count - FIFO_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_cmd;
    end

endmodule

// File: rtl/core/prcd_back.sv
// ----------------------------------------------------------------------------
// prcd_back
// Expands one run command into output-register pixel writes, one per cycle
// if not stalled: tail pixels backward from the chunk end, then head forward.
// ----------------------------------------------------------------------------
module prcd_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cmd_valid,
    output logic                             o_pop,
    input  prcd_pkg::t_cmd                   i_cmd,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [prcd_pkg::OUT_ADDR_W-1:0]  o_pixel_addr,
    output logic [7:0]                       o_red,
    output logic [7:0]                       o_green,
    output logic [7:0]                       o_blue,
    output logic                             o_opaque,
    output logic                             o_last,
    output logic                             o_overrun
);
    import prcd_pkg::*;

    localparam int EXT_W = ADDR_BITS + OUT_ADDR_W;

    t_cmd                  r_cmd;
    logic [OFF_W-1:0]      r_toff, r_hoff;
    logic [CNT_W-1:0]      r_tail_left, r_head_left;
    logic                  r_out_valid;
    logic [OUT_ADDR_W-1:0] r_addr;
    logic [RGB_W-1:0]      r_rgb;
    logic                  r_opaque, r_last, r_ovr;

    logic                  busy, emit, v_last, in_tail;
    logic [CNT_W:0]        left_sum;
    logic [OFF_W-1:0]      off;
    logic [ADDR_BITS-1:0]  addr;
    logic [EXT_W-1:0]      addr_ext;

    assign busy     = (r_tail_left != '0) || (r_head_left != '0);
    assign emit     = busy && (!r_out_valid || i_out_ready);
    assign left_sum = {1'b0, r_tail_left} + {1'b0, r_head_left};
    assign v_last   = (left_sum == (CNT_W+1)'(1));
    assign o_pop    = i_cmd_valid && (!busy || (emit && v_last));
    assign in_tail  = (r_tail_left != '0);
    assign off      = in_tail ? r_toff : r_hoff;
    assign addr     = {r_cmd.chunk, off};
    assign addr_ext = {{OUT_ADDR_W{1'b0}}, addr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_left <= '0;
            r_head_left <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_tail_left <= i_cmd.tail_cnt;
                r_head_left <= i_cmd.head_cnt;
            end else if (emit) begin
                if (in_tail) r_tail_left <= r_tail_left - CNT_W'(1);
                else         r_head_left <= r_head_left - CNT_W'(1);
            end
            if (emit)             r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd  <= i_cmd;
            r_toff <= i_cmd.tail_off;
            r_hoff <= i_cmd.head_off;
        end else if (emit) begin
            if (in_tail) r_toff <= r_toff - OFF_W'(1);
            else         r_hoff <= r_hoff + OFF_W'(1);
        end
        if (emit) begin
            r_addr   <= addr_ext[OUT_ADDR_W-1:0];
            r_rgb    <= r_cmd.rgb;
            r_opaque <= r_cmd.opaque;
            r_last   <= v_last;
            r_ovr    <= r_cmd.ovr;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_addr = r_addr;
    assign o_red        = r_rgb[23:16];
    assign o_green      = r_rgb[15:8];
    assign o_blue       = r_rgb[7:0];
    assign o_opaque     = r_opaque;
    assign o_last       = r_last;
    assign o_overrun    = r_ovr;

endmodule
